// File: design/emsi_pkg.sv
// Shared types, codes and match patterns for the EMSI send handshake.
`default_nettype none
package emsi_pkg;

	localparam int DAT_LEN = 10;
	localparam int SEQ_LEN = 14;
	localparam logic [6:0] CHAR_CR = 7'h0d;
	localparam logic [6:0] CHAR_LF = 7'h0a;
	localparam logic [6:0] CHAR_SPACE = 7'h20;

	localparam logic [7:0] HS_TIMEOUT_RST = 8'd60;
	localparam logic [7:0] RS_TIMEOUT_RST = 8'd20;
	localparam logic [3:0] MAX_TRIES_RST = 4'd6;

	typedef enum logic [1:0] {
		CFG_HS_TIMEOUT = 2'd0,
		CFG_RS_TIMEOUT = 2'd1,
		CFG_MAX_TRIES  = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		KIND_START = 2'd0,
		KIND_BYTE  = 2'd1,
		KIND_TICK  = 2'd2,
		KIND_FAULT = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ACT_NONE    = 3'd0,
		ACT_SEND    = 3'd1,
		ACT_ACK     = 3'd2,
		ACT_OK      = 3'd3,
		ACT_TIMEOUT = 3'd4,
		ACT_LINK    = 3'd5
	} act_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_WAIT = 2'd1
	} phase_t;

	typedef struct packed {
		logic [7:0] hs_timeout;
		logic [7:0] rs_timeout;
		logic [3:0] max_tries;
	} cfg_t;

	typedef struct packed {
		phase_t     phase;
		logic [3:0] try_count;
		logic [7:0] hs_left;
		logic [7:0] rs_left;
		logic [2:0] flags;
	} st_t;

	typedef struct packed {
		logic [1:0] count;
		act_t       act0;
		act_t       act1;
	} res_t;

	function automatic logic [6:0] pat_dat(input logic [3:0] idx);
		logic [6:0] c;
		case (idx)
			4'd0, 4'd1: c = 7'h2a;
			4'd2: c = 7'h45;
			4'd3: c = 7'h4d;
			4'd4: c = 7'h53;
			4'd5: c = 7'h49;
			4'd6: c = 7'h5f;
			4'd7: c = 7'h44;
			4'd8: c = 7'h41;
			4'd9: c = 7'h54;
			default: c = 7'h00;
		endcase
		return c;
	endfunction

	function automatic logic [6:0] pat_req(input logic [3:0] idx);
		logic [6:0] c;
		case (idx)
			4'd0, 4'd1: c = 7'h2a;
			4'd2: c = 7'h45;
			4'd3: c = 7'h4d;
			4'd4: c = 7'h53;
			4'd5: c = 7'h49;
			4'd6: c = 7'h5f;
			4'd7: c = 7'h52;
			4'd8: c = 7'h45;
			4'd9: c = 7'h51;
			4'd10: c = 7'h41;
			4'd11: c = 7'h37;
			4'd12: c = 7'h37;
			4'd13: c = 7'h45;
			default: c = 7'h00;
		endcase
		return c;
	endfunction

	function automatic logic [6:0] pat_ack(input logic [3:0] idx);
		logic [6:0] c;
		case (idx)
			4'd0, 4'd1: c = 7'h2a;
			4'd2: c = 7'h45;
			4'd3: c = 7'h4d;
			4'd4: c = 7'h53;
			4'd5: c = 7'h49;
			4'd6: c = 7'h5f;
			4'd7: c = 7'h41;
			4'd8: c = 7'h43;
			4'd9: c = 7'h4b;
			4'd10: c = 7'h41;
			4'd11: c = 7'h34;
			4'd12: c = 7'h39;
			4'd13: c = 7'h30;
			default: c = 7'h00;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

// File: design/emsi_step.sv
// Next-state and result logic for one input word of the EMSI send handshake.
`default_nettype none
module emsi_step #(
	parameter int LINE_LIMIT = 1024,
	localparam int LEN_W = $clog2(LINE_LIMIT + 1)
) (
	input  wire logic [1:0]       kind,
	input  wire logic [7:0]       rx_byte,
	input  wire emsi_pkg::cfg_t   cfg,
	input  wire emsi_pkg::st_t    st,
	input  wire logic [LEN_W-1:0] len,
	output emsi_pkg::st_t         st_nxt,
	output logic [LEN_W-1:0]      len_nxt,
	output emsi_pkg::res_t        res
);

	logic [6:0] ch;
	logic [3:0] pidx;
	logic [7:0] hs_dec;
	logic [7:0] rs_dec;

	assign ch = rx_byte[6:0];
	assign pidx = len[3:0];
	assign hs_dec = (st.hs_left != 8'd0) ? st.hs_left - 8'd1 : 8'd0;
	assign rs_dec = (st.rs_left != 8'd0) ? st.rs_left - 8'd1 : 8'd0;

	always_comb begin
		st_nxt = st;
		len_nxt = len;
		res.count = 2'd0;
		res.act0 = emsi_pkg::ACT_NONE;
		res.act1 = emsi_pkg::ACT_NONE;
		case (emsi_pkg::kind_t'(kind))
			emsi_pkg::KIND_START: begin
				len_nxt = '0;
				st_nxt.flags = 3'b111;
				res.count = 2'd1;
				if (cfg.max_tries == 4'd0) begin
					st_nxt.phase = emsi_pkg::PH_IDLE;
					st_nxt.try_count = 4'd0;
					res.act0 = emsi_pkg::ACT_TIMEOUT;
				end else begin
					st_nxt.phase = emsi_pkg::PH_WAIT;
					st_nxt.try_count = 4'd1;
					st_nxt.hs_left = cfg.hs_timeout;
					st_nxt.rs_left = cfg.rs_timeout;
					res.act0 = emsi_pkg::ACT_SEND;
				end
			end
			emsi_pkg::KIND_FAULT: begin
				if (st.phase == emsi_pkg::PH_WAIT) begin
					st_nxt.phase = emsi_pkg::PH_IDLE;
					res.count = 2'd1;
					res.act0 = emsi_pkg::ACT_LINK;
				end
			end
			emsi_pkg::KIND_TICK: begin
				if (st.phase == emsi_pkg::PH_WAIT) begin
					st_nxt.hs_left = hs_dec;
					st_nxt.rs_left = rs_dec;
					if (rs_dec == 8'd0 && st.try_count >= cfg.max_tries) begin
						st_nxt.phase = emsi_pkg::PH_IDLE;
						res.count = 2'd1;
						res.act0 = emsi_pkg::ACT_TIMEOUT;
					end else if (rs_dec == 8'd0) begin
						st_nxt.try_count = st.try_count + 4'd1;
						st_nxt.rs_left = cfg.rs_timeout;
						len_nxt = '0;
						st_nxt.flags = 3'b111;
						res.act0 = emsi_pkg::ACT_SEND;
						if (hs_dec == 8'd0) begin
							st_nxt.phase = emsi_pkg::PH_IDLE;
							res.count = 2'd2;
							res.act1 = emsi_pkg::ACT_TIMEOUT;
						end else begin
							res.count = 2'd1;
						end
					end else if (hs_dec == 8'd0) begin
						st_nxt.phase = emsi_pkg::PH_IDLE;
						res.count = 2'd1;
						res.act0 = emsi_pkg::ACT_TIMEOUT;
					end
				end
			end
			emsi_pkg::KIND_BYTE: begin
				if (st.phase == emsi_pkg::PH_WAIT) begin
					if (ch == emsi_pkg::CHAR_CR || ch == emsi_pkg::CHAR_LF) begin
						if (len != '0) begin
							if (len >= LEN_W'(emsi_pkg::DAT_LEN) && st.flags[0]) begin
								res.count = 2'd2;
								res.act0 = emsi_pkg::ACT_ACK;
								res.act1 = emsi_pkg::ACT_ACK;
								st_nxt.rs_left = st.rs_left >> 2;
							end else if (len >= LEN_W'(emsi_pkg::SEQ_LEN) && st.flags[1]) begin
								// request line: no action
							end else if (len >= LEN_W'(emsi_pkg::SEQ_LEN) && st.flags[2]) begin
								st_nxt.phase = emsi_pkg::PH_IDLE;
								res.count = 2'd1;
								res.act0 = emsi_pkg::ACT_OK;
							end
							len_nxt = '0;
							st_nxt.flags = 3'b111;
						end
					end else if (ch >= emsi_pkg::CHAR_SPACE) begin
						if (len >= LEN_W'(LINE_LIMIT)) begin
							len_nxt = '0;
							st_nxt.flags = 3'b111;
						end else begin
							if (len < LEN_W'(emsi_pkg::DAT_LEN) && ch != emsi_pkg::pat_dat(pidx))
								st_nxt.flags[0] = 1'b0;
							if (len < LEN_W'(emsi_pkg::SEQ_LEN)) begin
								if (ch != emsi_pkg::pat_req(pidx))
									st_nxt.flags[1] = 1'b0;
								if (ch != emsi_pkg::pat_ack(pidx))
									st_nxt.flags[2] = 1'b0;
							end
							len_nxt = len + LEN_W'(1);
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

// File: design/emsi_data_send_handshake.sv
// Top level of the EMSI send handshake: config registers, state and result queue.
//
// Usage:
//   Input channel (item_valid / item_stall) carries one event word: kind and
//   rx_byte. Output channel (result_valid / result_stall) carries one result
//   word: action and last. An event gives zero, one or two result words; last
//   marks the final one of an event. Events with no result give no word.
//   An event is evaluated in the cycle it is accepted and its words sit in a
//   four-entry result queue from the next cycle.
//   Throughput is one event per cycle while item_stall is low; an event
//   giving two words is popped a word at a time, so the queue occupancy
//   sets item_stall (raised with three or more words queued).
//   Configuration: cfg_write_en with cfg_index 0 (handshake timeout), 1
//   (resend timeout) or 2 (max tries) and cfg_data; other indexes are ignored.
//   Reset clears the queue, returns to idle and loads 60 / 20 / 6.
//   A stalled receiver holds the head word; once the queue is full enough,
//   item_stall holds off further events until words drain.
`default_nettype none
module emsi_data_send_handshake #(
	parameter int LINE_LIMIT = 1024
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       item_valid,
	output logic            item_stall,
	input  wire logic [1:0] kind,
	input  wire logic [7:0] rx_byte,
	output logic            result_valid,
	input  wire logic       result_stall,
	output logic [2:0]      action,
	output logic            last,
	input  wire logic       cfg_write_en,
	input  wire logic [1:0] cfg_index,
	input  wire logic [7:0] cfg_data
);

	localparam int LEN_W = $clog2(LINE_LIMIT + 1);

	emsi_pkg::cfg_t   cfg_q;
	emsi_pkg::st_t    st_q;
	emsi_pkg::st_t    st_nxt;
	logic [LEN_W-1:0] len_q;
	logic [LEN_W-1:0] len_nxt;
	emsi_pkg::res_t   res;

	logic [3:0] fifo_q [4];
	logic [1:0] wptr_q;
	logic [1:0] rptr_q;
	logic [2:0] count_q;
	logic       push;
	logic       pop;
	logic [1:0] push_n;

	assign item_stall = (count_q > 3'd2);
	assign push = item_valid && !item_stall;
	assign pop = result_valid && !result_stall;
	assign push_n = push ? res.count : 2'd0;
	assign result_valid = (count_q != 3'd0);
	assign action = fifo_q[rptr_q][3:1];
	assign last = fifo_q[rptr_q][0];

	emsi_step #(.LINE_LIMIT(LINE_LIMIT)) u_step (
		.kind    (kind),
		.rx_byte (rx_byte),
		.cfg     (cfg_q),
		.st      (st_q),
		.len     (len_q),
		.st_nxt  (st_nxt),
		.len_nxt (len_nxt),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hs_timeout <= emsi_pkg::HS_TIMEOUT_RST;
			cfg_q.rs_timeout <= emsi_pkg::RS_TIMEOUT_RST;
			cfg_q.max_tries <= emsi_pkg::MAX_TRIES_RST;
		end else if (cfg_write_en) begin
			case (emsi_pkg::cfg_idx_t'(cfg_index))
				emsi_pkg::CFG_HS_TIMEOUT: cfg_q.hs_timeout <= cfg_data;
				emsi_pkg::CFG_RS_TIMEOUT: cfg_q.rs_timeout <= cfg_data;
				emsi_pkg::CFG_MAX_TRIES: cfg_q.max_tries <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase <= emsi_pkg::PH_IDLE;
			st_q.try_count <= 4'd0;
			st_q.hs_left <= 8'd0;
			st_q.rs_left <= 8'd0;
			st_q.flags <= 3'b111;
			len_q <= '0;
		end else if (push) begin
			st_q <= st_nxt;
			len_q <= len_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 2'd0;
			rptr_q <= 2'd0;
			count_q <= 3'd0;
		end else begin
			wptr_q <= wptr_q + push_n;
			rptr_q <= rptr_q + {1'b0, pop};
			count_q <= count_q + {1'b0, push_n} - {2'b00, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push_n != 2'd0)
			fifo_q[wptr_q] <= {res.act0, (push_n == 2'd1)};
		if (push_n == 2'd2)
			fifo_q[wptr_q + 2'd1] <= {res.act1, 1'b1};
	end

endmodule
`default_nettype wire

// File: design/emsi_data_send_handshake_chk.sv
// Port-level checker for the EMSI send handshake, bound to the top level.
`default_nettype none
module emsi_data_send_handshake_chk (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       item_valid,
	input wire logic       item_stall,
	input wire logic [1:0] kind,
	input wire logic       result_valid,
	input wire logic       result_stall,
	input wire logic [2:0] action,
	input wire logic       last
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result word dropped while stalled");

	a_hold_word: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(action) && $stable(last))
		else $error("result word changed while stalled");

	a_action_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (action == emsi_pkg::ACT_SEND || action == emsi_pkg::ACT_ACK ||
			action == emsi_pkg::ACT_OK || action == emsi_pkg::ACT_TIMEOUT ||
			action == emsi_pkg::ACT_LINK))
		else $error("result word carries no action");

	a_start_result: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && kind == emsi_pkg::KIND_START |=> result_valid)
		else $error("start word gave no result");

endmodule

bind emsi_data_send_handshake emsi_data_send_handshake_chk u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.kind         (kind),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.action       (action),
	.last         (last)
);
`default_nettype wire

// File: bench/testbench.sv
// Self-checking testbench for the EMSI send handshake: event words in, action words out.
`timescale 1ns / 1ps
module testbench;
	import emsi_pkg::*;

	localparam int LINE_LIMIT = 1024;
	localparam int LIMIT_CYCLES = 400000;
	localparam int QUIET_CYCLES = 8;
	localparam int HOLD_CYCLES = 300;
	localparam int SEGMENT_ITEMS = 30;
	localparam int SEGMENTS = 4;
	localparam logic [1:0] CFG_UNUSED = 2'd3;
	localparam logic [8*SEQ_LEN-1:0] DAT_TXT = {32'h0, 80'h2a2a454d53495f444154};
	localparam logic [8*SEQ_LEN-1:0] REQ_TXT = 112'h2a2a454d53495f52455141373745;
	localparam logic [8*SEQ_LEN-1:0] ACK_TXT = 112'h2a2a454d53495f41434b41343930;

	typedef struct packed {
		act_t act;
		logic last;
	} word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	logic [1:0] kind = KIND_START;
	logic [7:0] rx_byte = 8'h00;
	logic result_valid;
	logic result_stall = 1'b0;
	logic [2:0] action;
	logic last;
	logic cfg_write_en = 1'b0;
	logic [1:0] cfg_index = CFG_HS_TIMEOUT;
	logic [7:0] cfg_data = 8'h00;

	word_t due_words[$];
	int bad_words = 0;
	int live_items = 0;
	int cycles = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	logic hold_on = 1'b0;
	event hold_go;

	logic [7:0] cfg_hs;
	logic [7:0] cfg_rs;
	logic [3:0] cfg_tries;
	phase_t st_phase;
	logic [3:0] st_try;
	logic [7:0] st_hs_left;
	logic [7:0] st_rs_left;
	int line_len;
	logic [2:0] line_match;

	emsi_data_send_handshake #(
		.LINE_LIMIT(LINE_LIMIT)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.kind(kind),
		.rx_byte(rx_byte),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.action(action),
		.last(last),
		.cfg_write_en(cfg_write_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("testbench failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		result_stall <= hold_on || ($urandom_range(99) < recv_stall_pct);
	end

	// long receiver hold-off, counted here so the sender keeps pushing
	always begin
		@(hold_go);
		hold_on <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_on <= 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			check_word(action, last);
	end

	task automatic check_word(input logic [2:0] got_act, input logic got_last);
		word_t want;
		if (due_words.size() == 0) begin
			bad_words++;
			if (bad_words <= 10)
				$display("unexpected word: action %0d last %0d", got_act, got_last);
		end else begin
			want = due_words.pop_front();
			if (got_act !== want.act || got_last !== want.last) begin
				bad_words++;
				if (bad_words <= 10)
					$display("mismatch: expected action %0d last %0d, got action %0d last %0d",
						want.act, want.last, got_act, got_last);
			end
		end
	endtask

	function automatic logic [6:0] text_char(input logic [8*SEQ_LEN-1:0] txt, input int n,
			input int pos);
		logic [7:0] c;
		c = txt[8*(n-1-pos) +: 8];
		return c[6:0];
	endfunction

	function automatic logic [6:0] rand_text();
		logic [31:0] r;
		r = $urandom_range(32, 127);
		return r[6:0];
	endfunction

	function automatic logic [7:0] rand_byte();
		logic [31:0] r;
		r = $urandom_range(255);
		return r[7:0];
	endfunction

	function automatic logic coin();
		logic [31:0] r;
		r = $urandom_range(1);
		return r[0];
	endfunction

	function automatic void reset_line();
		line_len = 0;
		line_match = 3'b111;
	endfunction

	task automatic predict_event(input kind_t k, input logic [7:0] b, output bit live);
		logic [6:0] ch;
		act_t acts[$];
		word_t w;
		bit closed;
		ch = b[6:0];
		closed = 1'b0;
		live = (k == KIND_START) || (st_phase == PH_WAIT);
		if (k == KIND_START) begin
			reset_line();
			if (cfg_tries == 4'd0) begin
				st_phase = PH_IDLE;
				st_try = 4'd0;
				acts.push_back(ACT_TIMEOUT);
			end else begin
				st_phase = PH_WAIT;
				st_try = 4'd1;
				st_hs_left = cfg_hs;
				st_rs_left = cfg_rs;
				acts.push_back(ACT_SEND);
			end
		end else if (st_phase == PH_WAIT) begin
			case (k)
				KIND_FAULT: begin
					st_phase = PH_IDLE;
					acts.push_back(ACT_LINK);
				end
				KIND_TICK: begin
					if (st_hs_left != 8'd0)
						st_hs_left = st_hs_left - 8'd1;
					if (st_rs_left != 8'd0)
						st_rs_left = st_rs_left - 8'd1;
					if (st_rs_left == 8'd0) begin
						if (st_try >= cfg_tries) begin
							st_phase = PH_IDLE;
							acts.push_back(ACT_TIMEOUT);
							closed = 1'b1;
						end else begin
							st_try = st_try + 4'd1;
							st_rs_left = cfg_rs;
							reset_line();
							acts.push_back(ACT_SEND);
						end
					end
					if (!closed && st_hs_left == 8'd0) begin
						st_phase = PH_IDLE;
						acts.push_back(ACT_TIMEOUT);
					end
				end
				default: begin
					if (ch == CHAR_CR || ch == CHAR_LF) begin
						if (line_len != 0) begin
							if (line_len >= DAT_LEN && line_match[0]) begin
								acts.push_back(ACT_ACK);
								acts.push_back(ACT_ACK);
								st_rs_left = st_rs_left >> 2;
							end else if (line_len >= SEQ_LEN && line_match[1]) begin
								// request line: nothing to do
							end else if (line_len >= SEQ_LEN && line_match[2]) begin
								st_phase = PH_IDLE;
								acts.push_back(ACT_OK);
							end
							reset_line();
						end
					end else if (ch >= CHAR_SPACE) begin
						if (line_len >= LINE_LIMIT) begin
							reset_line();
						end else begin
							if (line_len < DAT_LEN && ch != text_char(DAT_TXT, DAT_LEN, line_len))
								line_match[0] = 1'b0;
							if (line_len < SEQ_LEN) begin
								if (ch != text_char(REQ_TXT, SEQ_LEN, line_len))
									line_match[1] = 1'b0;
								if (ch != text_char(ACK_TXT, SEQ_LEN, line_len))
									line_match[2] = 1'b0;
							end
							line_len++;
						end
					end
				end
			endcase
		end
		foreach (acts[i]) begin
			w.act = acts[i];
			w.last = (i == acts.size() - 1);
			due_words.push_back(w);
		end
	endtask

	task automatic send_word(input kind_t k, input logic [7:0] b);
		bit live;
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		kind <= k;
		rx_byte <= b;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		predict_event(k, b, live);
		if (live)
			live_items++;
	endtask

	task automatic send_seq(input logic [8*SEQ_LEN-1:0] txt, input int n);
		for (int i = 0; i < n; i++)
			send_word(KIND_BYTE, {coin(), text_char(txt, n, i)});
	endtask

	task automatic drain_results();
		item_valid <= 1'b0;
		while (due_words.size() != 0) @(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		cfg_write_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		case (idx)
			CFG_HS_TIMEOUT: cfg_hs = val;
			CFG_RS_TIMEOUT: cfg_rs = val;
			CFG_MAX_TRIES: cfg_tries = val[3:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	function automatic logic [7:0] pick_timer();
		logic [31:0] r;
		case ($urandom_range(7))
			0: r = 0;
			1: r = 1;
			2: r = 255;
			default: r = $urandom_range(2, 12);
		endcase
		return r[7:0];
	endfunction

	task automatic pick_settings();
		logic [31:0] r;
		logic [31:0] hi;
		case ($urandom_range(7))
			0: r = 0;
			1: r = 1;
			2: r = 15;
			default: r = $urandom_range(2, 6);
		endcase
		hi = $urandom_range(15);
		write_reg(CFG_HS_TIMEOUT, pick_timer());
		write_reg(CFG_RS_TIMEOUT, pick_timer());
		write_reg(CFG_MAX_TRIES, {hi[3:0], r[3:0]});
		if ($urandom_range(3) == 0)
			write_reg(CFG_UNUSED, rand_byte());
	endtask

	task automatic send_line();
		logic [8*SEQ_LEN-1:0] txt;
		logic [6:0] chars[$];
		logic [31:0] r;
		int n;
		txt = '0;
		n = 0;
		case ($urandom_range(3))
			0: begin txt = DAT_TXT; n = DAT_LEN; end
			1: begin txt = REQ_TXT; n = SEQ_LEN; end
			2: begin txt = ACK_TXT; n = SEQ_LEN; end
			default: n = 0;
		endcase
		if (n == 0) begin
			repeat ($urandom_range(0, 20)) chars.push_back(rand_text());
		end else begin
			for (int i = 0; i < n; i++)
				chars.push_back(text_char(txt, n, i));
			if ($urandom_range(4) == 0)
				chars[$urandom_range(n - 1)] = rand_text();
			if ($urandom_range(5) == 0) begin
				r = $urandom_range(n - 1);
				while (chars.size() > r) chars.pop_back();
			end
			if ($urandom_range(3) == 0)
				repeat ($urandom_range(1, 6)) chars.push_back(rand_text());
		end
		foreach (chars[i]) begin
			if ($urandom_range(15) == 0) begin
				r = $urandom_range(31);
				if (r[6:0] == CHAR_CR || r[6:0] == CHAR_LF)
					r = 0;
				send_word(KIND_BYTE, {coin(), r[6:0]});
			end
			send_word(KIND_BYTE, {coin(), chars[i]});
		end
		send_word(KIND_BYTE, {coin(), coin() ? CHAR_CR : CHAR_LF});
	endtask

	task automatic random_traffic(input int target);
		int stop_at;
		int r;
		stop_at = live_items + target;
		while (live_items < stop_at) begin
			r = $urandom_range(19);
			if (st_phase == PH_IDLE && r < 16)
				send_word(KIND_START, rand_byte());
			else if (r < 9)
				send_line();
			else if (r < 13)
				repeat ($urandom_range(1, 3)) send_word(KIND_TICK, rand_byte());
			else if (r == 13)
				send_word(KIND_FAULT, rand_byte());
			else if (r == 14)
				send_word(KIND_START, rand_byte());
			else
				send_word(KIND_BYTE, rand_byte());
		end
	endtask

	// runs on the reset register values: 60 / 20 / 6
	task automatic test_idle_and_lines();
		send_word(KIND_BYTE, 8'h41);
		send_word(KIND_TICK, rand_byte());
		send_word(KIND_FAULT, rand_byte());
		send_word(KIND_START, 8'hff);
		send_word(KIND_START, 8'h00);
		send_word(KIND_BYTE, {1'b0, CHAR_CR});
		send_word(KIND_BYTE, 8'h00);
		send_word(KIND_BYTE, 8'hff);
		send_word(KIND_BYTE, {1'b1, CHAR_CR});
		send_seq(DAT_TXT, DAT_LEN);
		send_word(KIND_BYTE, {1'b1, CHAR_LF});
		repeat (5) send_word(KIND_TICK, rand_byte());
		send_word(KIND_FAULT, rand_byte());
		drain_results();
	endtask

	task automatic test_timer_edges();
		write_reg(CFG_MAX_TRIES, 8'ha0);
		send_word(KIND_START, rand_byte());
		drain_results();
		write_reg(CFG_HS_TIMEOUT, 8'd0);
		write_reg(CFG_RS_TIMEOUT, 8'd0);
		write_reg(CFG_MAX_TRIES, 8'hf1);
		send_word(KIND_START, rand_byte());
		send_word(KIND_TICK, rand_byte());
		drain_results();
		// both timers expire on one tick: resend then timeout
		write_reg(CFG_HS_TIMEOUT, 8'd2);
		write_reg(CFG_RS_TIMEOUT, 8'd1);
		write_reg(CFG_MAX_TRIES, 8'd3);
		send_word(KIND_START, rand_byte());
		send_word(KIND_TICK, rand_byte());
		send_word(KIND_TICK, rand_byte());
		drain_results();
		write_reg(CFG_HS_TIMEOUT, 8'd0);
		write_reg(CFG_RS_TIMEOUT, 8'd5);
		write_reg(CFG_MAX_TRIES, 8'd15);
		write_reg(CFG_UNUSED, 8'hff);
		send_word(KIND_START, rand_byte());
		send_word(KIND_TICK, rand_byte());
		drain_results();
	endtask

	task automatic test_long_line();
		write_reg(CFG_HS_TIMEOUT, 8'd255);
		write_reg(CFG_RS_TIMEOUT, 8'd255);
		write_reg(CFG_MAX_TRIES, 8'd15);
		send_word(KIND_START, rand_byte());
		repeat (LINE_LIMIT) send_word(KIND_BYTE, {coin(), rand_text()});
		// overflow byte must be dropped, not start the next line
		send_word(KIND_BYTE, {coin(), text_char(ACK_TXT, SEQ_LEN, 0)});
		send_seq(ACK_TXT, SEQ_LEN);
		send_word(KIND_BYTE, {coin(), CHAR_CR});
		drain_results();
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		-> hold_go;
		repeat (24) send_word(KIND_START, rand_byte());
		drain_results();
	endtask

	task automatic test_random(input int idle_pct, input int stall_pct);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		for (int s = 0; s < SEGMENTS; s++) begin
			drain_results();
			pick_settings();
			random_traffic(SEGMENT_ITEMS);
		end
		drain_results();
	endtask

	initial begin
		cfg_hs = HS_TIMEOUT_RST;
		cfg_rs = RS_TIMEOUT_RST;
		cfg_tries = MAX_TRIES_RST;
		st_phase = PH_IDLE;
		st_try = 4'd0;
		st_hs_left = 8'd0;
		st_rs_left = 8'd0;
		reset_line();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_and_lines();
		test_timer_edges();
		test_long_line();
		test_backpressure();
		test_random(18, 83);
		test_random(83, 18);
		test_random(0, 0);
		drain_results();
		if (bad_words == 0 && due_words.size() == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule

// File: emsi_data_send_handshake.f
design/emsi_pkg.sv
design/emsi_step.sv
design/emsi_data_send_handshake.sv
design/emsi_data_send_handshake_chk.sv
bench/testbench.sv
